[sv/rpf_pkg.sv]
// Package with the item types, protocol characters and helpers of the packet framer.
`timescale 1ns / 1ps
`default_nettype none

package rpf_pkg;

    localparam int MaxChars = 6;
    localparam int CntW     = $clog2(MaxChars + 1);

    localparam logic [7:0] ChStart  = 8'h24;
    localparam logic [7:0] ChHash   = 8'h23;
    localparam logic [7:0] ChEsc    = 8'h7D;
    localparam logic [7:0] EscXor   = 8'h20;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
        logic       empty_packet;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
    } t_out_item;

    // Characters produced by one input item, first character in slot 0.
    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        logic [CntW-1:0]          count;
        logic                     closes;
    } t_char_list;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? {4'h3, v} : (8'h57 + {4'h0, v});
    endfunction

endpackage

`default_nettype wire

[sv/rpf_encode.sv]
// Packet state and the encoder that turns one item into its framed characters.
`timescale 1ns / 1ps
`default_nettype none

module rpf_encode
    import rpf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_in_item   i_item,
    output t_char_list      o_list
);

    logic       r_in_packet;
    logic [7:0] r_sum;
    logic       n_in_packet;
    logic [7:0] n_sum;

    logic [7:0]      base_sum;
    logic [7:0]      new_sum;
    logic [7:0]      trail_sum;
    logic            is_esc;
    logic            trailer;
    logic [CntW-1:0] k;

    always_comb begin
        base_sum  = r_in_packet ? r_sum : 8'h00;
        new_sum   = base_sum + i_item.payload_byte;
        trail_sum = i_item.empty_packet ? base_sum : new_sum;
        is_esc    = (i_item.payload_byte == ChStart) || (i_item.payload_byte == ChHash)
                 || (i_item.payload_byte == ChEsc);
        trailer   = i_item.empty_packet || i_item.last_byte;

        o_list = '0;
        k      = '0;
        if (!r_in_packet) begin
            o_list.chars[k] = ChStart;
            k = k + 1'b1;
        end
        if (!i_item.empty_packet) begin
            if (is_esc) begin
                o_list.chars[k] = ChEsc;
                k = k + 1'b1;
                o_list.chars[k] = i_item.payload_byte ^ EscXor;
                k = k + 1'b1;
            end else begin
                o_list.chars[k] = i_item.payload_byte;
                k = k + 1'b1;
            end
        end
        if (trailer) begin
            o_list.chars[k] = ChHash;
            k = k + 1'b1;
            o_list.chars[k] = hex_digit(trail_sum[7:4]);
            k = k + 1'b1;
            o_list.chars[k] = hex_digit(trail_sum[3:0]);
            k = k + 1'b1;
        end
        o_list.count  = k;
        o_list.closes = trailer;

        n_in_packet = r_in_packet;
        n_sum       = r_sum;
        if (i_accept) begin
            n_in_packet = !trailer;
            n_sum       = trailer ? 8'h00 : new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_sum       <= 8'h00;
        end else begin
            r_in_packet <= n_in_packet;
            r_sum       <= n_sum;
        end
    end

endmodule

`default_nettype wire

[sv/rpf_shifter.sv]
// Output stage that holds the characters of one item and sends them one per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module rpf_shifter
    import rpf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_char_list i_list,
    output logic            o_can_load,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_item
);

    logic [MaxChars-1:0][7:0] r_chars;
    logic [CntW-1:0]          r_cnt;
    logic                     r_closes;
    logic [MaxChars-1:0][7:0] n_chars;
    logic [CntW-1:0]          n_cnt;
    logic                     n_closes;
    logic                     take;

    always_comb begin
        o_valid              = (r_cnt != '0);
        take                 = o_valid && i_ready;
        o_can_load           = (r_cnt == '0) || ((r_cnt == CntW'(1)) && i_ready);
        o_item.out_byte      = r_chars[0];
        o_item.end_of_packet = r_closes && (r_cnt == CntW'(1));

        n_chars  = r_chars;
        n_cnt    = r_cnt;
        n_closes = r_closes;
        if (i_load) begin
            n_chars  = i_list.chars;
            n_cnt    = i_list.count;
            n_closes = i_list.closes;
        end else if (take) begin
            n_chars = {8'h00, r_chars[MaxChars-1:1]};
            n_cnt   = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_closes <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_closes <= n_closes;
        end
        r_chars <= n_chars;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxChars))
        else $error("character count out of range");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("item loaded over unsent characters");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_load) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("character count did not step down on a send");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (i_list.count != '0))
        else $error("item produced no characters");

endmodule

`default_nettype wire

[sv/rsp_packet_framer.sv]
// Top level of the remote serial protocol packet framer.
// Input channel: one payload byte per item with last_byte and empty_packet flags.
// The first item of a packet is preceded by '$'. The bytes '$', '#' and '}' go
// out as '}' followed by the byte XOR 0x20. A last byte, or an empty-packet
// request, closes the packet with '#' and two lower-case hex checksum digits;
// end_of_packet marks the low digit. The checksum is the byte sum mod 256.
// Output channel: one character per item, valid and ready on both sides.
// The first character of an item is valid the cycle after it is accepted. An
// item producing N characters (1 to 6) holds the output stage until its last
// character is taken, so plain bytes inside a packet flow at one item per cycle
// while the receiver is ready; escapes, the opening '$' and the trailer keep an
// item in the stage until all its characters are sent. The output stage takes the
// next item in the same cycle its last character is taken.
// Reset clears the packet state and empties the output stage; no packet is open.
// When the receiver stalls, the current character holds and the input channel
// accepts nothing until the output stage is empty or its final character is taken.
`timescale 1ns / 1ps
`default_nettype none

module rsp_packet_framer
    import rpf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    t_char_list list;
    logic       can_load;
    logic       accept;

    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    rpf_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_list   (list)
    );

    rpf_shifter u_shifter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_list     (list),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_data)
    );

endmodule

`default_nettype wire

[dv/rpf_checker.sv]
// Checker that predicts the framed characters and compares them with the block output.
`timescale 1ns / 1ps

module rpf_checker
    import rpf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out_data,
    output int             o_errors,
    output int             o_pending
);

    t_out_item  expected_chars[$];
    logic       frame_open = 1'b0;
    logic [7:0] frame_sum = 8'h00;
    int         error_count = 0;

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        if (nibble < 4'd10) begin
            return 8'h30 + {4'h0, nibble};
        end
        return 8'h61 + {4'h0, nibble} - 8'd10;
    endfunction

    task automatic queue_char(input logic [7:0] ch, input logic eop);
        t_out_item c;
        c.out_byte      = ch;
        c.end_of_packet = eop;
        expected_chars  = {expected_chars, c};
    endtask

    task automatic frame_item(input t_in_item item);
        logic [7:0] b;
        b = item.payload_byte;
        if (!frame_open) begin
            queue_char(ChStart, 1'b0);
            frame_open = 1'b1;
            frame_sum  = 8'h00;
        end
        if (!item.empty_packet) begin
            if (b == ChStart || b == ChHash || b == ChEsc) begin
                queue_char(ChEsc, 1'b0);
                queue_char(b ^ EscXor, 1'b0);
            end else begin
                queue_char(b, 1'b0);
            end
            frame_sum = frame_sum + b;
        end
        if (item.empty_packet || item.last_byte) begin
            queue_char(ChHash, 1'b0);
            queue_char(hex_char(frame_sum[7:4]), 1'b0);
            queue_char(hex_char(frame_sum[3:0]), 1'b1);
            frame_open = 1'b0;
            frame_sum  = 8'h00;
        end
    endtask

    always @(posedge i_clk) begin : compare_chars
        t_out_item want;
        if (!i_rst_n) begin
            expected_chars.delete();
            frame_open = 1'b0;
            frame_sum  = 8'h00;
        end else begin
            // The character taken at this edge always belongs to an earlier item.
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("%0t: unexpected character 0x%02h eop=%0b", $realtime,
                                 i_out_data.out_byte, i_out_data.end_of_packet);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_data.out_byte !== want.out_byte ||
                        i_out_data.end_of_packet !== want.end_of_packet) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("%0t: expected 0x%02h eop=%0b, got 0x%02h eop=%0b",
                                     $realtime, want.out_byte, want.end_of_packet,
                                     i_out_data.out_byte, i_out_data.end_of_packet);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                frame_item(i_in_data);
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_chars.size();
    end

endmodule

[dv/tb.sv]
// Testbench top that drives payload items into the packet framer and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import rpf_pkg::*;

    logic      i_clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_char;
    int        fail_count;
    int        chars_pending;
    logic      calm = 1'b1;
    int        sent_count = 0;

    rsp_packet_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_char)
    );

    rpf_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_char),
        .o_errors    (fail_count),
        .o_pending   (chars_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("rsp_packet_framer test failed");
        $finish;
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic t_in_item pack_item(input logic [7:0] b, input logic last,
                                           input logic empty);
        t_in_item item;
        item.payload_byte = b;
        item.last_byte    = last;
        item.empty_packet = empty;
        return item;
    endfunction

    task automatic send_item(input t_in_item item);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge i_clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic send_random_packet();
        int         len;
        int         i;
        logic       close_empty;
        logic [7:0] b;
        calm = (sent_count >= 90 && sent_count < 120) || sent_count >= 180;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
        close_empty = (len == 0) || ($urandom_range(0, 7) == 0);
        for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 11))
                0: b = ChStart;
                1: b = ChHash;
                2: b = ChEsc;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_item(pack_item(b, (i == len - 1) && !close_empty, 1'b0));
        end
        if (close_empty) begin
            send_item(pack_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Empty request with no packet open.
        send_item(pack_item(8'hA5, 1'b0, 1'b1));
        send_item(pack_item(8'h00, 1'b1, 1'b0));
        send_item(pack_item(8'hFF, 1'b1, 1'b0));
        // Escaped single-byte packets give the longest output runs, then escapes inside a longer packet.
        send_item(pack_item(ChStart, 1'b1, 1'b0));
        send_item(pack_item(ChHash, 1'b1, 1'b0));
        send_item(pack_item(ChEsc, 1'b1, 1'b0));
        send_item(pack_item(ChEsc, 1'b0, 1'b0));
        send_item(pack_item(ChStart, 1'b0, 1'b0));
        send_item(pack_item(ChHash, 1'b0, 1'b0));
        send_item(pack_item(8'h5A, 1'b1, 1'b0));
        // The checksum wraps past 255.
        send_item(pack_item(8'h80, 1'b0, 1'b0));
        send_item(pack_item(8'h80, 1'b0, 1'b0));
        send_item(pack_item(8'h01, 1'b1, 1'b0));
        // Empty request closes an open packet; both flags set means empty.
        send_item(pack_item(8'h41, 1'b0, 1'b0));
        send_item(pack_item(ChStart, 1'b1, 1'b1));
        send_item(pack_item(ChEsc, 1'b1, 1'b1));
        send_item(pack_item(8'h30, 1'b0, 1'b0));
        send_item(pack_item(8'hFF, 1'b0, 1'b1));

        while (sent_count < 220) begin
            send_random_packet();
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        while (chars_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("rsp_packet_framer test passed");
        end else begin
            $display("rsp_packet_framer test failed");
        end
        $finish;
    end

endmodule
